// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

// ===== sv/bfsam_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsam_pkg
// Types and constants shared by the adjacency matrix BFS engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bfsam_pkg;

   localparam int VERTEX_W         = 5;
   localparam int ROW_W            = 32;
   localparam int COUNT_W          = 6;
   localparam int MAX_VERTICES_DEF = 32;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   typedef struct packed {
      logic                command;
      logic [VERTEX_W-1:0] row_index;
      logic [ROW_W-1:0]    row_bits;
      logic [VERTEX_W-1:0] start_vertex;
   } req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic                last;
      logic                bad_start;
   } rsp_type;

   typedef struct packed {
      logic                found;
      logic [VERTEX_W-1:0] index;
   } scan_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_FETCH,
      ST_SCAN,
      ST_BAD
   } state_type;

endpackage

`default_nettype wire

// ===== sv/bfsam_scan.sv =====
// ----------------------------------------------------------------------------
// bfsam_scan
// Finds the lowest-numbered neighbor that is in range and not yet visited.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsam_scan (
   input  wire logic [bfsam_pkg::ROW_W-1:0] row,
   input  wire logic [bfsam_pkg::ROW_W-1:0] mask,
   input  wire logic [bfsam_pkg::ROW_W-1:0] visited,
   output bfsam_pkg::scan_type              scan
);

   logic [bfsam_pkg::ROW_W-1:0]    fresh;
   logic [bfsam_pkg::ROW_W-1:0]    low;
   logic [bfsam_pkg::VERTEX_W-1:0] idx;

   always_comb begin
      fresh = row & mask & ~visited;
      // isolate lowest set bit
      low   = fresh & (~fresh + bfsam_pkg::ROW_W'(1));
      idx   = '0;
      for (int i = 0; i < bfsam_pkg::ROW_W; i++) begin
         if (low[i]) begin
            idx = idx | bfsam_pkg::VERTEX_W'(i);
         end
      end
      scan.found = |fresh;
      scan.index = idx;
   end

endmodule

`default_nettype wire

// ===== sv/bfs_adjacency_matrix.sv =====
// ----------------------------------------------------------------------------
// bfs_adjacency_matrix
// Breadth-first search engine over a stored directed adjacency matrix.
// ----------------------------------------------------------------------------
//  channel  dir  handshake                         payload
//  req      in   req_valid / req_stall             req_data (load row or search)
//  rsp      out  rsp_valid / rsp_stall             rsp_data (visit order)
//  csr      in   csr_write_enable                  csr_write_data (vertex count)
//
//  A load writes its row when the request is accepted. A bad start passes
//  through ST_BAD, where it waits out any rsp stall. A search pops each vertex
//  from the queue (queue pop), reads its row (row read), lets the single
//  lowest-bit scan unit enqueue one neighbor a cycle, then emits the vertex.
//  req_stall is high for the whole search; a stalled rsp holds the sequencer.
//  Reset clears the rows (per-row valid bits), the queue pointers and control.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bfs_adjacency_matrix #(
   parameter int MAX_VERTICES = bfsam_pkg::MAX_VERTICES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire bfsam_pkg::req_type                req_data,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      bfsam_pkg::rsp_type                rsp_data,
   input  wire logic                              csr_write_enable,
   input  wire logic [bfsam_pkg::COUNT_W-1:0]     csr_write_data
);

   localparam int ROWS = (MAX_VERTICES < bfsam_pkg::ROW_W) ? MAX_VERTICES
                                                           : bfsam_pkg::ROW_W;
   localparam int IDXW = $clog2(ROWS);
   localparam int CW   = $clog2(ROWS + 1);
   localparam logic [bfsam_pkg::COUNT_W-1:0] ROWS_C = bfsam_pkg::COUNT_W'(ROWS);

   bfsam_pkg::state_type state_ff, state_in;

   logic [bfsam_pkg::COUNT_W-1:0]  count_ff;
   logic [CW-1:0]                  head_ff;
   logic [CW-1:0]                  tail_ff;
   logic [bfsam_pkg::ROW_W-1:0]    visited_ff;
   logic [bfsam_pkg::ROW_W-1:0]    mask_ff;
   logic [bfsam_pkg::VERTEX_W-1:0] w_ff;
   logic [bfsam_pkg::VERTEX_W-1:0] fifo_rd_ff;
   logic [bfsam_pkg::ROW_W-1:0]    adj_rd_ff;
   logic [ROWS-1:0]                adj_valid_ff;
   logic                           rsp_valid_ff;
   bfsam_pkg::rsp_type             rsp_data_ff;

   logic [bfsam_pkg::ROW_W-1:0]    adj_mem  [ROWS];
   logic [bfsam_pkg::VERTEX_W-1:0] fifo_mem [ROWS];

   logic                           req_fire;
   logic                           out_free;
   logic [bfsam_pkg::COUNT_W-1:0]  lim;
   logic                           bad;
   logic [bfsam_pkg::ROW_W-1:0]    mask_calc;
   logic                           load_we;
   logic                           is_search;
   bfsam_pkg::scan_type            scan;

   logic start_search, do_pop, do_fetch, do_enq, do_emit, emit_bad;

   // ------------------------------------------------------------------
   // shared neighbor scan unit
   // ------------------------------------------------------------------
   bfsam_scan u_scan (
      .row     (adj_rd_ff),
      .mask    (mask_ff),
      .visited (visited_ff),
      .scan    (scan)
   );

   // ------------------------------------------------------------------
   // input decode
   // ------------------------------------------------------------------
   always_comb begin
      req_fire  = req_valid && !req_stall;
      out_free  = !rsp_valid_ff || !rsp_stall;
      lim       = (count_ff > ROWS_C) ? ROWS_C : count_ff;
      bad       = bfsam_pkg::COUNT_W'(req_data.start_vertex) >= lim;
      is_search = req_data.command == bfsam_pkg::CMD_SEARCH;
      for (int i = 0; i < bfsam_pkg::ROW_W; i++) begin
         mask_calc[i] = bfsam_pkg::COUNT_W'(i) < lim;
      end
      // rows beyond the supported depth are never read back
      load_we   = req_fire && (req_data.command == bfsam_pkg::CMD_LOAD) &&
                  (bfsam_pkg::COUNT_W'(req_data.row_index) < ROWS_C);
   end

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfsam_pkg::ST_IDLE: begin
            if (req_fire && is_search) begin
               state_in = bad ? bfsam_pkg::ST_BAD : bfsam_pkg::ST_POP;
            end
         end
         bfsam_pkg::ST_POP:   state_in = bfsam_pkg::ST_FETCH;
         bfsam_pkg::ST_FETCH: state_in = bfsam_pkg::ST_SCAN;
         bfsam_pkg::ST_SCAN: begin
            if (!scan.found && out_free) begin
               state_in = (head_ff == tail_ff) ? bfsam_pkg::ST_IDLE
                                               : bfsam_pkg::ST_POP;
            end
         end
         bfsam_pkg::ST_BAD: begin
            if (out_free) begin
               state_in = bfsam_pkg::ST_IDLE;
            end
         end
         default: state_in = bfsam_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall    = 1'b1;
      start_search = 1'b0;
      do_pop       = 1'b0;
      do_fetch     = 1'b0;
      do_enq       = 1'b0;
      do_emit      = 1'b0;
      emit_bad     = 1'b0;
      unique case (state_ff)
         bfsam_pkg::ST_IDLE: begin
            req_stall    = 1'b0;
            start_search = req_valid && is_search && !bad;
         end
         bfsam_pkg::ST_POP:   do_pop   = 1'b1;
         bfsam_pkg::ST_FETCH: do_fetch = 1'b1;
         bfsam_pkg::ST_SCAN: begin
            do_enq  = scan.found;
            do_emit = !scan.found && out_free;
         end
         bfsam_pkg::ST_BAD:   emit_bad = out_free;
         default: ;
      endcase
   end

   // ------------------------------------------------------------------
   // control registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfsam_pkg::ST_IDLE;
         count_ff     <= bfsam_pkg::COUNT_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         adj_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            count_ff <= csr_write_data;
         end
         if (start_search) begin
            head_ff <= '0;
            tail_ff <= CW'(1);
         end else begin
            if (do_pop) begin
               head_ff <= head_ff + CW'(1);
            end
            if (do_enq) begin
               tail_ff <= tail_ff + CW'(1);
            end
         end
         if (load_we) begin
            adj_valid_ff[req_data.row_index[IDXW-1:0]] <= 1'b1;
         end
         if (do_emit || emit_bad) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // datapath registers and memories
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (start_search) begin
         visited_ff <= bfsam_pkg::ROW_W'(1) << req_data.start_vertex;
         mask_ff    <= mask_calc;
      end else if (do_enq) begin
         visited_ff <= visited_ff | (bfsam_pkg::ROW_W'(1) << scan.index);
      end
      if (do_fetch) begin
         w_ff <= fifo_rd_ff;
      end
      if (do_emit) begin
         rsp_data_ff.vertex    <= w_ff;
         rsp_data_ff.last      <= head_ff == tail_ff;
         rsp_data_ff.bad_start <= 1'b0;
      end else if (emit_bad) begin
         rsp_data_ff.vertex    <= '0;
         rsp_data_ff.last      <= 1'b1;
         rsp_data_ff.bad_start <= 1'b1;
      end
   end

   // vertex queue
   always_ff @(posedge clock) begin
      if (start_search) begin
         fifo_mem[0] <= req_data.start_vertex;
      end else if (do_enq) begin
         fifo_mem[tail_ff[IDXW-1:0]] <= scan.index;
      end
      if (do_pop) begin
         fifo_rd_ff <= fifo_mem[head_ff[IDXW-1:0]];
      end
   end

   // adjacency rows; a row never loaded reads as zero
   always_ff @(posedge clock) begin
      if (load_we) begin
         adj_mem[req_data.row_index[IDXW-1:0]] <= req_data.row_bits;
      end
      if (do_fetch) begin
         adj_rd_ff <= adj_valid_ff[fifo_rd_ff[IDXW-1:0]]
                      ? adj_mem[fifo_rd_ff[IDXW-1:0]] : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   `ASSERT_NEVER(a_head_past_tail, clock, reset, head_ff > tail_ff)
   `ASSERT_PROP(a_pop_nonempty, clock, reset,
                (state_ff == bfsam_pkg::ST_POP) |-> (head_ff < tail_ff))
   `ASSERT_PROP(a_visited_queued, clock, reset,
                (state_ff == bfsam_pkg::ST_POP || state_ff == bfsam_pkg::ST_FETCH ||
                 state_ff == bfsam_pkg::ST_SCAN) |->
                ($countones(visited_ff) == int'(tail_ff)))
   `ASSERT_PROP(a_enq_in_range, clock, reset,
                (state_ff == bfsam_pkg::ST_SCAN && scan.found) |-> mask_ff[scan.index])

endmodule

`default_nettype wire
